[design/key_debounce_event_gen_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the key debounce event generator
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_EVENT_GEN_UNIT_ASSERT_SVH
`define KEY_DEBOUNCE_EVENT_GEN_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define KDEG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define KDEG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/kdeg_pkg.sv]
// ---------------------------------------------------------------------------
// kdeg_pkg
// Shared constants, event codes and types of the key debounce event generator.
// ---------------------------------------------------------------------------
package kdeg_pkg;

  // Key count and derived widths
  localparam int NUM_KEYS = 4;
  localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int EQ_DEPTH = 2 * NUM_KEYS;
  localparam int EQ_IDX_W = (EQ_DEPTH > 1) ? $clog2(EQ_DEPTH) : 1;
  localparam int EQ_CNT_W = $clog2(EQ_DEPTH + 1);

  // Field widths
  localparam int CNT_W  = 8;
  localparam int HOLD_W = 16;
  localparam int KIND_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Event codes
  localparam logic [KIND_W-1:0] EV_PRESS   = 3'd0;
  localparam logic [KIND_W-1:0] EV_SHORT   = 3'd1;
  localparam logic [KIND_W-1:0] EV_LONG    = 3'd2;
  localparam logic [KIND_W-1:0] EV_REPEAT  = 3'd3;
  localparam logic [KIND_W-1:0] EV_RELEASE = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW   = 3'd4;

  // Per-key state word held in the state memory
  typedef struct packed {
    logic              prev_sample;
    logic              stable_pressed;
    logic [CNT_W-1:0]  stable_count;
    logic [HOLD_W-1:0] hold_count;
    logic              long_done;
  } kdeg_entry_t;

  // Up to two events pushed for one key
  typedef struct packed {
    logic              en0;
    logic [KIND_W-1:0] kind0;
    logic              en1;
    logic [KIND_W-1:0] kind1;
    logic [KEY_W-1:0]  key;
  } kdeg_push_t;

  // Remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } kdeg_mod_stat_t;

endpackage

[design/kdeg_state_ram.sv]
// ---------------------------------------------------------------------------
// kdeg_state_ram
// Per-key state memory, one write and one registered read port; entries
// not yet written read as zero through a valid bit per entry.
// ---------------------------------------------------------------------------
module kdeg_state_ram import kdeg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [KEY_W-1:0] wr_addr,
  input  kdeg_entry_t      wr_data,
  input  logic             rd_en,
  input  logic [KEY_W-1:0] rd_addr,
  output kdeg_entry_t      rd_data
);

  kdeg_entry_t             mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]     valid_r;
  kdeg_entry_t             rd_word_r;
  logic                    rd_valid_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule

[design/kdeg_mod_unit.sv]
// ---------------------------------------------------------------------------
// kdeg_mod_unit
// Serial restoring remainder, one quotient bit per cycle; reports whether
// the dividend is an exact multiple of the divisor.
// ---------------------------------------------------------------------------
module kdeg_mod_unit import kdeg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HOLD_W-1:0] dividend,
  input  logic [HOLD_W-1:0] divisor,
  output kdeg_mod_stat_t    stat
);

  localparam int STEP_W = $clog2(HOLD_W);

  logic              busy_r;
  logic              done_r;
  logic              zero_r;
  logic [STEP_W-1:0] step_r;
  logic [HOLD_W-1:0] dvd_r;
  logic [HOLD_W-1:0] dvs_r;
  logic [HOLD_W-1:0] rem_r;
  logic [HOLD_W:0]   trial;
  logic [HOLD_W-1:0] rem_nxt;

  // Shift in one dividend bit and subtract where it fits
  always_comb begin
    trial = {rem_r, dvd_r[HOLD_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = HOLD_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[HOLD_W-1:0];
    end
  end

  // Iterate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      zero_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        dvd_r  <= {dvd_r[HOLD_W-2:0], 1'b0};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(HOLD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          zero_r <= (rem_nxt == '0);
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.zero = zero_r;

endmodule

[design/kdeg_event_queue.sv]
// ---------------------------------------------------------------------------
// kdeg_event_queue
// Collects the events of one tick, then hands them out one request at a
// time through the output register, marking the final one.
// ---------------------------------------------------------------------------
module kdeg_event_queue import kdeg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  kdeg_push_t          push,
  input  logic                drain,
  input  logic [NUM_KEYS-1:0] keys_down,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [KEY_W-1:0]    out_key_index,
  output logic [KIND_W-1:0]   out_event_kind,
  output logic [NUM_KEYS-1:0] out_keys_down,
  output logic                out_last,
  output logic                drained
);

  logic [KEY_W-1:0]    key_q  [EQ_DEPTH];
  logic [KIND_W-1:0]   kind_q [EQ_DEPTH];
  logic [EQ_CNT_W-1:0] wr_cnt_r;
  logic [EQ_CNT_W-1:0] rd_cnt_r;
  logic [EQ_CNT_W-1:0] wr_cnt_p1;
  logic [EQ_CNT_W-1:0] rd_cnt_p1;
  logic                out_valid_r;
  logic                load;

  assign wr_cnt_p1 = wr_cnt_r + 1'b1;
  assign rd_cnt_p1 = rd_cnt_r + 1'b1;
  assign load      = drain && (rd_cnt_r != wr_cnt_r) && (!out_valid_r || !out_stall);
  assign drained   = drain && (rd_cnt_r == wr_cnt_r) && !out_valid_r;

  // Store pushed events
  always_ff @(posedge clk) begin
    if (push.en0) begin
      key_q[wr_cnt_r[EQ_IDX_W-1:0]]  <= push.key;
      kind_q[wr_cnt_r[EQ_IDX_W-1:0]] <= push.kind0;
    end
    if (push.en1) begin
      key_q[wr_cnt_p1[EQ_IDX_W-1:0]]  <= push.key;
      kind_q[wr_cnt_p1[EQ_IDX_W-1:0]] <= push.kind1;
    end
  end

  // Advance write and read counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_cnt_r <= '0;
      rd_cnt_r <= '0;
    end else if (clear) begin
      wr_cnt_r <= '0;
      rd_cnt_r <= '0;
    end else begin
      wr_cnt_r <= wr_cnt_r + EQ_CNT_W'(push.en0) + EQ_CNT_W'(push.en1);
      if (load) begin
        rd_cnt_r <= rd_cnt_p1;
      end
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_key_index  <= key_q[rd_cnt_r[EQ_IDX_W-1:0]];
      out_event_kind <= kind_q[rd_cnt_r[EQ_IDX_W-1:0]];
      out_keys_down  <= keys_down;
      out_last       <= (rd_cnt_p1 == wr_cnt_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule

[design/key_debounce_event_gen_unit.sv]
// ---------------------------------------------------------------------------
// key_debounce_event_gen_unit
// Debounce and press-event generator: per-key state in a small memory,
// updated key by key on every scan tick; events queued and sent in order.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   raw_levels
//   out_     output     out_valid/out_stall key_index, event_kind, keys_down, last
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// A tick is accepted, then each key is read, updated and written back, with
// keys whose repeat phase is checked passing through the serial remainder
// unit; the tick's events are then sent one by one before the tick ends.
// No tick is taken until the previous tick's events have all been taken.
// Reset needs no clearing pass: the state memory has a valid bit per key.
// Output stalls hold the output register; cfg_ready is always high.
// ---------------------------------------------------------------------------
module key_debounce_event_gen_unit import kdeg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [NUM_KEYS-1:0]  in_raw_levels,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KEY_W-1:0]     out_key_index,
  output logic [KIND_W-1:0]    out_event_kind,
  output logic [NUM_KEYS-1:0]  out_keys_down,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  `include "key_debounce_event_gen_unit_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MOD,
    S_WRITE,
    S_DRAIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    debounce_r;
  logic [HOLD_W-1:0]   long_ticks_r;
  logic [HOLD_W-1:0]   repeat_start_r;
  logic [HOLD_W-1:0]   repeat_rate_r;
  logic [NUM_KEYS-1:0] mask_r;
  logic [NUM_KEYS-1:0] levels_r;
  logic [NUM_KEYS-1:0] down_r;
  logic [KEY_W-1:0]    key_r;
  kdeg_entry_t         ent_r, ent_nxt;
  logic                v0_r, v0_nxt;
  logic                v1_r, v1_nxt;
  logic [KIND_W-1:0]   k0_r, k0_nxt;
  logic [KIND_W-1:0]   k1_r, k1_nxt;
  logic                rep_r, rep_nxt;
  kdeg_entry_t         ram_rdata;
  kdeg_mod_stat_t      mod_stat;
  kdeg_push_t          push;
  logic [HOLD_W-1:0]   mod_dividend;
  logic [HOLD_W-1:0]   mod_divisor;
  logic                in_accept;
  logic                last_key;
  logic                q_drained;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign last_key  = (key_r == KEY_W'(NUM_KEYS - 1));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= 8'd3;
      long_ticks_r   <= 16'd50;
      repeat_start_r <= 16'd70;
      repeat_rate_r  <= 16'd12;
      mask_r         <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     debounce_r     <= cfg_wdata[CNT_W-1:0];
        REG_LONG_TICKS:   long_ticks_r   <= cfg_wdata[HOLD_W-1:0];
        REG_REPEAT_START: repeat_start_r <= cfg_wdata[HOLD_W-1:0];
        REG_REPEAT_RATE:  repeat_rate_r  <= cfg_wdata[HOLD_W-1:0];
        REG_ACTIVE_LOW:   mask_r         <= cfg_wdata[NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

  // Update one key: debounce, edge events, then hold events
  always_comb begin
    logic              s;
    logic [HOLD_W-1:0] h;
    s       = levels_r[key_r] ^ mask_r[key_r];
    h       = '0;
    ent_nxt = ram_rdata;
    v0_nxt  = 1'b0;
    v1_nxt  = 1'b0;
    k0_nxt  = EV_PRESS;
    k1_nxt  = EV_PRESS;
    rep_nxt = 1'b0;
    if (s == ram_rdata.prev_sample) begin
      if (ram_rdata.stable_count < debounce_r) begin
        ent_nxt.stable_count = ram_rdata.stable_count + 1'b1;
      end
    end else begin
      ent_nxt.stable_count = '0;
      ent_nxt.prev_sample  = s;
    end
    if (ent_nxt.stable_count >= debounce_r && s != ram_rdata.stable_pressed) begin
      ent_nxt.stable_pressed = s;
      v0_nxt = 1'b1;
      if (s) begin
        ent_nxt.hold_count = '0;
        ent_nxt.long_done  = 1'b0;
        k0_nxt = EV_PRESS;
      end else if (ram_rdata.long_done) begin
        k0_nxt = EV_RELEASE;
      end else begin
        k0_nxt = EV_SHORT;
        v1_nxt = 1'b1;
        k1_nxt = EV_RELEASE;
      end
    end
    if (ent_nxt.stable_pressed) begin
      h = ent_nxt.hold_count + 1'b1;
      ent_nxt.hold_count = h;
      if (!ent_nxt.long_done && h >= long_ticks_r) begin
        ent_nxt.long_done = 1'b1;
        if (v0_nxt) begin
          v1_nxt = 1'b1;
          k1_nxt = EV_LONG;
        end else begin
          v0_nxt = 1'b1;
          k0_nxt = EV_LONG;
        end
      end else if (ent_nxt.long_done && h >= repeat_start_r) begin
        // key held with no edge this tick: repeat depends on the phase
        v0_nxt  = 1'b1;
        k0_nxt  = EV_REPEAT;
        rep_nxt = 1'b1;
      end
    end
  end

  assign mod_dividend = ent_nxt.hold_count - repeat_start_r;
  assign mod_divisor  = (repeat_rate_r == '0) ? HOLD_W'(1) : repeat_rate_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_READ;
      S_READ:  state_nxt = S_EVAL;
      S_EVAL:  state_nxt = rep_nxt ? S_MOD : S_WRITE;
      S_MOD:   if (mod_stat.done) state_nxt = S_WRITE;
      S_WRITE: state_nxt = last_key ? S_DRAIN : S_READ;
      S_DRAIN: if (q_drained) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and per-key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      key_r   <= '0;
      down_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        levels_r <= in_raw_levels;
        key_r    <= '0;
        down_r   <= '0;
      end
      if (state_r == S_EVAL) begin
        ent_r <= ent_nxt;
        v0_r  <= v0_nxt;
        v1_r  <= v1_nxt;
        k0_r  <= k0_nxt;
        k1_r  <= k1_nxt;
        rep_r <= rep_nxt;
      end
      if (state_r == S_WRITE) begin
        down_r[key_r] <= ent_r.stable_pressed;
        if (!last_key) begin
          key_r <= key_r + 1'b1;
        end
      end
    end
  end

  // Push the key's events as it is written back
  always_comb begin
    push.en0  = (state_r == S_WRITE) && v0_r && (!rep_r || mod_stat.zero);
    push.kind0 = k0_r;
    push.en1  = (state_r == S_WRITE) && v1_r;
    push.kind1 = k1_r;
    push.key  = key_r;
  end

  kdeg_state_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (state_r == S_WRITE),
    .wr_addr (key_r),
    .wr_data (ent_r),
    .rd_en   (state_r == S_READ),
    .rd_addr (key_r),
    .rd_data (ram_rdata)
  );

  kdeg_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == S_EVAL) && rep_nxt),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .stat     (mod_stat)
  );

  kdeg_event_queue u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .clear          (in_accept),
    .push           (push),
    .drain          (state_r == S_DRAIN),
    .keys_down      (down_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_key_index  (out_key_index),
    .out_event_kind (out_event_kind),
    .out_keys_down  (out_keys_down),
    .out_last       (out_last),
    .drained        (q_drained)
  );

  // Checks
  `KDEG_ASSERT_SAME(a_out_only_draining, out_valid, state_r == S_DRAIN, "result outside drain")
  `KDEG_ASSERT_SAME(a_mod_only_waiting, mod_stat.busy, state_r == S_MOD, "remainder unit stray")
  `KDEG_ASSERT_NEXT(a_last_ends_tick, out_valid && out_last && !out_stall, !out_valid, "result after last")

endmodule
